// File: rtl/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 3;
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 32;

  localparam int CFG_W      = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;

  localparam logic [CFG_W-1:0]     CFG_FRAMES_RESET  = CFG_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = REG_IDX_W'(0);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// File: rtl/lru_page_replacement.sv
`timescale 1ns / 1ps

// LRU page replacement. Each request carries a page number; the block looks it up among the
// filled frames, refreshes the frame's last-use stamp on a hit, and on a fault fills the next
// empty frame or replaces the least recently used one among the first frames_in_use frames.
// Page numbers and stamps live in a single-port-read frame memory with a registered read. A
// request is accepted, then the block reads the frame memory once per filled frame, compares
// each registered read as it returns, and then writes back the frame in a step that also
// loads the result register. The first request after reset finds no filled frame and skips
// the scan. The write-back step is held for as long as the previous result still waits at
// the output, and a new request is taken while a result waits there. No clearing pass is
// needed after reset. frames_in_use sits at byte address 0; a value of 0 acts as 1 and a
// value above MAX_FRAMES acts as MAX_FRAMES.

module lru_page_replacement #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrupr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lrupr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lrupr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lrupr_pkg::PAGE_W-1:0]        in_page_number,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_fault,
  output logic [lrupr_pkg::FRAME_W-1:0]       out_frame_index,
  output logic                                out_evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]        out_evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]       out_fault_count
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int MEM_W = PAGE_BITS + lrupr_pkg::STAMP_W;
  localparam int LIM_W = (CNT_W > lrupr_pkg::CFG_W) ? CNT_W : lrupr_pkg::CFG_W + 1;
  localparam int CFG_W = lrupr_pkg::CFG_W;

  logic [CFG_W-1:0]                  frames_in_use_r;
  logic [lrupr_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                              reg_write;
  logic [LIM_W-1:0]                  cfg_ext;
  logic [LIM_W-1:0]                  limit_ext;
  logic [CNT_W-1:0]                  limit;

  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [MEM_W-1:0]  mem_rdata;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[lrupr_pkg::APB_ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= lrupr_pkg::CFG_FRAMES_RESET;
    end else if (reg_write && reg_idx == lrupr_pkg::REG_FRAMES_IN_USE) begin
      frames_in_use_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      lrupr_pkg::REG_FRAMES_IN_USE: prdata = lrupr_pkg::APB_DATA_W'(frames_in_use_r);
      default:                      prdata = '0;
    endcase
  end

  always_comb begin
    cfg_ext = LIM_W'(frames_in_use_r);
    if (cfg_ext == '0) begin
      limit_ext = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(MAX_FRAMES)) begin
      limit_ext = LIM_W'(MAX_FRAMES);
    end else begin
      limit_ext = cfg_ext;
    end
    limit = limit_ext[CNT_W-1:0];
  end

  lrupr_frame_mem #(
    .DEPTH  (MAX_FRAMES),
    .DATA_W (MEM_W)
  ) u_frame_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  lrupr_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .limit             (limit),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fault         (out_fault),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .mem_re            (mem_re),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata)
  );

endmodule

// File: rtl/lrupr_frame_mem.sv
`timescale 1ns / 1ps

module lrupr_frame_mem #(
  parameter int DEPTH  = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int DATA_W = lrupr_pkg::PAGE_BITS_DEF + lrupr_pkg::STAMP_W,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lrupr_ctrl.sv
`timescale 1ns / 1ps

module lrupr_ctrl #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int CNT_W = $clog2(MAX_FRAMES + 1),
  localparam int MEM_W = PAGE_BITS + lrupr_pkg::STAMP_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [CNT_W-1:0]                limit,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lrupr_pkg::PAGE_W-1:0]    in_page_number,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_fault,
  output logic [lrupr_pkg::FRAME_W-1:0]   out_frame_index,
  output logic                            out_evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]    out_evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]   out_fault_count,
  output logic                            mem_re,
  output logic [IDX_W-1:0]                mem_raddr,
  input  logic [MEM_W-1:0]                mem_rdata,
  output logic                            mem_we,
  output logic [IDX_W-1:0]                mem_waddr,
  output logic [MEM_W-1:0]                mem_wdata
);

  localparam int STAMP_W = lrupr_pkg::STAMP_W;
  localparam int COUNT_W = lrupr_pkg::COUNT_W;
  localparam int PAGE_W  = lrupr_pkg::PAGE_W;
  localparam int FRAME_W = lrupr_pkg::FRAME_W;
  localparam int EXT_W   = (PAGE_BITS > PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int FX_W    = (IDX_W > FRAME_W) ? IDX_W : FRAME_W;

  lrupr_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]     filled_r;
  logic [CNT_W-1:0]     rd_cnt_r;
  logic                 cmp_vld_r;
  logic [STAMP_W-1:0]   access_r;
  logic [COUNT_W-1:0]   faults_r;
  logic                 out_valid_r;

  logic [PAGE_BITS-1:0] page_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 hit_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [STAMP_W-1:0]   best_stamp_r;
  logic [PAGE_BITS-1:0] best_tag_r;

  logic                 out_fault_r;
  logic [FRAME_W-1:0]   out_frame_index_r;
  logic                 out_evicted_valid_r;
  logic [PAGE_W-1:0]    out_evicted_page_r;
  logic [COUNT_W-1:0]   out_fault_count_r;

  logic                 accept;
  logic                 scan_more;
  logic                 out_free;
  logic                 do_update;
  logic [EXT_W-1:0]     page_ext;
  logic [PAGE_BITS-1:0] in_tag;
  logic [PAGE_BITS-1:0] rd_tag;
  logic [STAMP_W-1:0]   rd_stamp;
  logic                 full;
  logic                 evict;
  logic [IDX_W-1:0]     slot;
  logic [FX_W-1:0]      slot_ext;
  logic [EXT_W-1:0]     victim_ext;
  logic [COUNT_W-1:0]   faults_nxt;
  logic [STAMP_W-1:0]   access_nxt;
  logic                 take_best;

  assign accept    = in_valid && in_ready;
  assign scan_more = rd_cnt_r < filled_r;
  assign out_free  = !out_valid_r || out_ready;
  assign page_ext  = EXT_W'(in_page_number);
  assign in_tag    = page_ext[PAGE_BITS-1:0];
  assign rd_tag    = mem_rdata[MEM_W-1 -: PAGE_BITS];
  assign rd_stamp  = mem_rdata[STAMP_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrupr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (filled_r == '0) ? lrupr_pkg::ST_UPDATE : lrupr_pkg::ST_SCAN;
        end
      end
      lrupr_pkg::ST_SCAN: begin
        if (!scan_more) begin
          state_nxt = lrupr_pkg::ST_UPDATE;
        end
      end
      lrupr_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_nxt = lrupr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lrupr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    do_update = 1'b0;
    unique case (state_r)
      lrupr_pkg::ST_IDLE:   in_ready  = 1'b1;
      lrupr_pkg::ST_SCAN:   mem_re    = scan_more;
      lrupr_pkg::ST_UPDATE: do_update = out_free;
      default: ;
    endcase
  end

  always_comb begin
    full  = filled_r >= limit;
    evict = !hit_r && full;
    if (hit_r) begin
      slot = hit_idx_r;
    end else if (!full) begin
      slot = IDX_W'(filled_r);
    end else begin
      slot = best_idx_r;
    end
    slot_ext   = FX_W'(slot);
    victim_ext = EXT_W'(best_tag_r);
    if (hit_r || faults_r == '1) begin
      faults_nxt = faults_r;
    end else begin
      faults_nxt = faults_r + COUNT_W'(1);
    end
    access_nxt = (access_r == '1) ? access_r : access_r + STAMP_W'(1);
    take_best  = (CNT_W'(cmp_idx_r) < limit)
                 && (cmp_idx_r == '0 || rd_stamp < best_stamp_r);
  end

  assign mem_raddr = rd_cnt_r[IDX_W-1:0];
  assign mem_we    = do_update;
  assign mem_waddr = slot;
  assign mem_wdata = {page_r, access_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrupr_pkg::ST_IDLE;
      filled_r    <= '0;
      rd_cnt_r    <= '0;
      cmp_vld_r   <= 1'b0;
      access_r    <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= mem_re;
      if (accept) begin
        rd_cnt_r <= '0;
      end else if (mem_re) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
      if (do_update) begin
        access_r    <= access_nxt;
        faults_r    <= faults_nxt;
        out_valid_r <= 1'b1;
        if (!hit_r && !full) begin
          filled_r <= filled_r + CNT_W'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_cnt_r[IDX_W-1:0];
    if (accept) begin
      page_r <= in_tag;
      hit_r  <= 1'b0;
    end else if (cmp_vld_r) begin
      if (!hit_r && rd_tag == page_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      if (take_best) begin
        best_idx_r   <= cmp_idx_r;
        best_stamp_r <= rd_stamp;
        best_tag_r   <= rd_tag;
      end
    end
    if (do_update) begin
      out_fault_r         <= !hit_r;
      out_frame_index_r   <= slot_ext[FRAME_W-1:0];
      out_evicted_valid_r <= evict;
      out_evicted_page_r  <= evict ? victim_ext[PAGE_W-1:0] : '0;
      out_fault_count_r   <= faults_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fault         = out_fault_r;
  assign out_frame_index   = out_frame_index_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_count   = out_fault_count_r;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int APB_ADDR_W     = lrupr_pkg::APB_ADDR_W;
  localparam int APB_DATA_W     = lrupr_pkg::APB_DATA_W;
  localparam int PAGE_W         = lrupr_pkg::PAGE_W;
  localparam int FRAME_W        = lrupr_pkg::FRAME_W;
  localparam int COUNT_W        = lrupr_pkg::COUNT_W;
  localparam int STAMP_W        = lrupr_pkg::STAMP_W;
  localparam int CFG_W          = lrupr_pkg::CFG_W;
  localparam int MAX_FRAMES_DEF = lrupr_pkg::MAX_FRAMES_DEF;

  localparam int LONG_HOLD = 300;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int PHASE_LIMIT [PHASES] = '{1, 8, 0, 15, 2, 9, 5, 3, 7, 12, 6, 4};
  localparam logic [APB_ADDR_W-1:0] FRAMES_ADDR =
    APB_ADDR_W'(4 * lrupr_pkg::REG_FRAMES_IN_USE);
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR =
    APB_ADDR_W'(4 * (lrupr_pkg::REG_FRAMES_IN_USE + 1));

  typedef enum logic [1:0] {
    ROW_PAGE,
    ROW_CFG_WRITE,
    ROW_CFG_READ
  } row_kind_t;

  typedef struct packed {
    logic               fault;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_count;
  } access_outcome_t;

  typedef struct {
    row_kind_t        kind;
    logic [APB_ADDR_W-1:0] addr;
    logic [31:0]      value;
    bit               known;
    access_outcome_t  want;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic [PAGE_W-1:0]     in_page_number;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_fault;
  logic [FRAME_W-1:0]    out_frame_index;
  logic                  out_evicted_valid;
  logic [PAGE_W-1:0]     out_evicted_page;
  logic [COUNT_W-1:0]    out_fault_count;

  logic [PAGE_W-1:0]  page_tag [MAX_FRAMES_DEF];
  logic [STAMP_W-1:0] last_stamp [MAX_FRAMES_DEF];
  int                 frames_loaded = 0;
  logic [STAMP_W-1:0] use_clock = '0;
  logic [COUNT_W-1:0] fault_total = '0;
  logic [CFG_W-1:0]   frames_cfg = lrupr_pkg::CFG_FRAMES_RESET;

  access_outcome_t expected_outcomes [$];
  script_row_t     script [$];
  bit              known_valid;
  access_outcome_t known_outcome;
  bit              send_gaps;
  bit              recv_stalls;
  bit              hold_off_request;
  int              mismatches = 0;

  lru_page_replacement i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fault         (out_fault),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic access_outcome_t lru_access(input logic [PAGE_W-1:0] pg);
    access_outcome_t r;
    int limit;
    int slot;
    int i;
    bit hit;
    r = '0;
    limit = frames_cfg;
    if (limit == 0) limit = 1;
    if (limit > MAX_FRAMES_DEF) limit = MAX_FRAMES_DEF;
    hit = 1'b0;
    slot = 0;
    for (i = 0; i < frames_loaded; i++) begin
      if (!hit && page_tag[i] == pg) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (!hit) begin
      if (frames_loaded < limit) begin
        slot = frames_loaded;
        frames_loaded++;
      end else begin
        slot = 0;
        for (i = 1; i < limit; i++) begin
          if (last_stamp[i] < last_stamp[slot]) slot = i;
        end
        r.evicted = 1'b1;
        r.evicted_page = page_tag[slot];
      end
      page_tag[slot] = pg;
      if (fault_total != '1) fault_total++;
    end
    last_stamp[slot] = use_clock;
    if (use_clock != '1) use_clock++;
    r.fault = !hit;
    r.frame = FRAME_W'(slot);
    r.fault_count = fault_total;
    return r;
  endfunction

  function automatic void add_page(input logic [PAGE_W-1:0] pg);
    script_row_t row;
    row = '{ROW_PAGE, '0, 32'(pg), 1'b0, '0};
    script.insert(script.size(), row);
  endfunction

  function automatic void add_known_page(input logic [PAGE_W-1:0] pg, input logic fault,
                                         input int frame, input logic evicted,
                                         input logic [PAGE_W-1:0] evicted_page,
                                         input int count);
    script_row_t row;
    row = '{ROW_PAGE, '0, 32'(pg), 1'b1,
            '{fault, FRAME_W'(frame), evicted, evicted_page, COUNT_W'(count)}};
    script.insert(script.size(), row);
  endfunction

  function automatic void add_cfg(input row_kind_t kind, input logic [APB_ADDR_W-1:0] addr,
                                  input logic [31:0] value);
    script_row_t row;
    row = '{kind, addr, value, 1'b0, '0};
    script.insert(script.size(), row);
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_page(input logic [PAGE_W-1:0] pg);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_page_number = pg;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr == FRAMES_ADDR) frames_cfg = data[CFG_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_frames_reg(input logic [31:0] want);
    logic [31:0] rd;
    apb_access(1'b0, FRAMES_ADDR, '0, rd);
    compare_field("frames_in_use", want, rd);
  endtask

  function automatic logic [31:0] cfg_word(input int value);
    return ($urandom() & 32'hFFFF_FFF0) | 32'(value);
  endfunction

  always @(posedge clk) begin
    access_outcome_t want;
    access_outcome_t predicted;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result arrived with no request pending");
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          compare_field("fault", 32'(want.fault), 32'(out_fault));
          compare_field("frame_index", 32'(want.frame), 32'(out_frame_index));
          compare_field("evicted_valid", 32'(want.evicted), 32'(out_evicted_valid));
          compare_field("evicted_page", 32'(want.evicted_page), 32'(out_evicted_page));
          compare_field("fault_count", 32'(want.fault_count), 32'(out_fault_count));
        end
      end
      if (in_valid && in_ready) begin
        predicted = lru_access(in_page_number);
        expected_outcomes.insert(expected_outcomes.size(),
                                 known_valid ? known_outcome : predicted);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  initial begin
    logic [31:0] rd;
    logic [PAGE_W-1:0] pool [16];
    logic [PAGE_W-1:0] pg;
    script_row_t row;
    int pool_size;
    int roll;
    bit last_phase;
    in_valid = 1'b0;
    in_page_number = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    known_valid = 1'b0;
    known_outcome = '0;
    send_gaps = 1'b0;
    recv_stalls = 1'b1;
    hold_off_request = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Fill four frames, refresh one, then force two evictions (the second evicts page zero).
    add_cfg(ROW_CFG_READ, FRAMES_ADDR, 32'(lrupr_pkg::CFG_FRAMES_RESET));
    add_known_page(16'h0000, 1'b1, 0, 1'b0, 16'h0000, 1);
    add_known_page(16'hFFFF, 1'b1, 1, 1'b0, 16'h0000, 2);
    add_known_page(16'h0000, 1'b0, 0, 1'b0, 16'h0000, 2);
    add_known_page(16'h5555, 1'b1, 2, 1'b0, 16'h0000, 3);
    add_known_page(16'hAAAA, 1'b1, 3, 1'b0, 16'h0000, 4);
    add_known_page(16'h1234, 1'b1, 1, 1'b1, 16'hFFFF, 5);
    add_known_page(16'hFFFF, 1'b1, 0, 1'b1, 16'h0000, 6);
    // A limit of zero acts as one; hits are still found beyond the limit.
    add_cfg(ROW_CFG_WRITE, FRAMES_ADDR, cfg_word(0));
    add_cfg(ROW_CFG_READ, FRAMES_ADDR, 32'd0);
    add_known_page(16'h5555, 1'b0, 2, 1'b0, 16'h0000, 6);
    add_known_page(16'h0F0F, 1'b1, 0, 1'b1, 16'hFFFF, 7);
    // A limit above the frame count acts as the full frame count.
    add_cfg(ROW_CFG_WRITE, FRAMES_ADDR, cfg_word(15));
    add_cfg(ROW_CFG_READ, FRAMES_ADDR, 32'd15);
    add_known_page(16'h0001, 1'b1, 4, 1'b0, 16'h0000, 8);
    add_known_page(16'h0002, 1'b1, 5, 1'b0, 16'h0000, 9);
    add_known_page(16'h0004, 1'b1, 6, 1'b0, 16'h0000, 10);
    add_known_page(16'h0008, 1'b1, 7, 1'b0, 16'h0000, 11);
    add_page(16'h0010);
    add_page(16'h8000);
    // A write outside the register map leaves the register alone.
    add_cfg(ROW_CFG_WRITE, UNMAPPED_ADDR, 32'd1);
    add_cfg(ROW_CFG_READ, FRAMES_ADDR, 32'd15);
    add_page(16'h0F0F);
    add_page(16'h0002);

    foreach (script[k]) begin
      row = script[k];
      if (row.kind == ROW_PAGE) begin
        known_valid = row.known;
        known_outcome = row.want;
        send_page(row.value[PAGE_W-1:0]);
      end else begin
        in_valid = 1'b0;
        wait_drained();
        if (row.kind == ROW_CFG_WRITE) begin
          apb_access(1'b1, row.addr, row.value, rd);
        end else begin
          check_frames_reg(row.value);
        end
      end
    end
    known_valid = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      in_valid = 1'b0;
      wait_drained();
      apb_access(1'b1, FRAMES_ADDR, cfg_word(PHASE_LIMIT[p]), rd);
      check_frames_reg(32'(PHASE_LIMIT[p]));
      last_phase = (p == PHASES - 1);
      send_gaps = !last_phase && $urandom_range(0, 3) != 0;
      recv_stalls = !last_phase && $urandom_range(0, 3) != 0;
      pool_size = $urandom_range(2, 16);
      for (int j = 0; j < 16; j++) pool[j] = PAGE_W'($urandom());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 20) hold_off_request = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          pg = pool[$urandom_range(0, pool_size - 1)];
        end else if (roll < 95) begin
          pg = PAGE_W'($urandom());
        end else begin
          pg = roll[0] ? '1 : '0;
        end
        send_page(pg);
      end
    end

    in_valid = 1'b0;
    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: lru_page_replacement.f
rtl/lrupr_pkg.sv
rtl/lrupr_frame_mem.sv
rtl/lrupr_ctrl.sv
rtl/lru_page_replacement.sv
test/tb_top.sv
